// ===== hdl/qpr_pkg.sv =====
// Shared constants and types for the quadrature position and rpm block.
package qpr_pkg;

	localparam int unsigned CPR_W  = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SCALE_W = 30;
	localparam int unsigned NUM_W  = DATA_W + SCALE_W;	// dp magnitude times scale
	localparam int unsigned DEN_W  = CPR_W + DATA_W;	// cpr times dt
	localparam int unsigned QUOT_W = DATA_W - 1;		// quotient below saturation
	localparam int unsigned STEP_W = 5;

	// rpm in Q4: 60 s * 1e6 us * 16
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 30'd960000000;

	localparam logic [CPR_W-1:0]  CPR_RESET = 16'd512;
	localparam logic [DATA_W-1:0] MIN_RESET = 32'd1000;

	// opcodes of an input word
	localparam logic [1:0] OP_EDGE_A = 2'd0;
	localparam logic [1:0] OP_EDGE_B = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// configuration register indexes
	localparam logic REG_CPR = 1'b0;
	localparam logic REG_MIN = 1'b1;

	localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

// ===== hdl/qpr_div.sv =====
// Restoring divider: one shared subtractor, one quotient bit per cycle, saturation test first.
module qpr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [qpr_pkg::NUM_W-1:0]    num,
	input  logic [qpr_pkg::DEN_W-1:0]    den,
	output logic [qpr_pkg::QUOT_W-1:0]   quot,
	output qpr_pkg::div_stat_t           stat
);

	logic                          busy_q;
	logic                          first_q;
	logic [qpr_pkg::STEP_W-1:0]    cnt_q;
	logic [qpr_pkg::DEN_W:0]       rem_q;
	logic [qpr_pkg::QUOT_W-1:0]    low_q;
	logic [qpr_pkg::QUOT_W-1:0]    quot_q;
	qpr_pkg::div_stat_t            stat_q;

	logic [qpr_pkg::DEN_W:0]       cand;
	logic [qpr_pkg::DEN_W+1:0]     diff;
	logic                          ge;

	// first pass compares the top of the numerator with den: q >= 2^31 exactly then
	assign cand = first_q ? rem_q : {rem_q[qpr_pkg::DEN_W-1:0], low_q[qpr_pkg::QUOT_W-1]};
	assign diff = {1'b0, cand} - {2'b00, den};
	assign ge   = ~diff[qpr_pkg::DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
			stat_q  <= '0;
		end else begin
			stat_q.done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= qpr_pkg::STEP_W'(qpr_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				if (first_q) begin
					first_q <= 1'b0;
					if (ge) begin
						busy_q      <= 1'b0;
						stat_q.done <= 1'b1;
						stat_q.ovf  <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						busy_q      <= 1'b0;
						stat_q.done <= 1'b1;
						stat_q.ovf  <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {{(qpr_pkg::DEN_W + 1 - (qpr_pkg::NUM_W - qpr_pkg::QUOT_W)){1'b0}},
				num[qpr_pkg::NUM_W-1:qpr_pkg::QUOT_W]};
			low_q  <= num[qpr_pkg::QUOT_W-1:0];
			quot_q <= '0;
		end else if (busy_q && !first_q) begin
			rem_q  <= ge ? diff[qpr_pkg::DEN_W:0] : cand;
			low_q  <= {low_q[qpr_pkg::QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[qpr_pkg::QUOT_W-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign stat = stat_q;

endmodule

// ===== hdl/quadrature_position_and_rpm.sv =====
// Top level: x4 quadrature position counter with tick-driven rpm estimate.
// Edge events, unused opcodes and ticks that leave the speed alone give a result in the cycle after acceptance.
// A tick that updates the speed steps through S_MUL, S_LOAD and S_DIV, where the divider
// gives one quotient bit per cycle or stops at its saturation test; no new word is taken meanwhile.
// The result registers hold the word until it is taken. Async reset clears position,
// levels, tick history and speed, and loads counts_per_rev 512 and min_interval_us 1000.
module quadrature_position_and_rpm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [qpr_pkg::DATA_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic                          level_a,
	input  logic                          level_b,
	input  logic [qpr_pkg::DATA_W-1:0]    time_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [qpr_pkg::DATA_W-1:0] position,
	output logic signed [qpr_pkg::DATA_W-1:0] speed_rpm_q4
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_LOAD = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [qpr_pkg::CPR_W-1:0]      cpr_q;
	logic [qpr_pkg::DATA_W-1:0]     min_q;
	logic                           last_a_q;
	logic                           last_b_q;
	logic [qpr_pkg::DATA_W-1:0]     count_q;
	logic [qpr_pkg::DATA_W-1:0]     tick_time_q;
	logic [qpr_pkg::DATA_W-1:0]     tick_count_q;
	logic [qpr_pkg::DATA_W-1:0]     speed_q;
	logic                           out_valid_q;
	logic                           neg_q;
	logic [qpr_pkg::DATA_W-1:0]     mag_q;
	logic [qpr_pkg::DATA_W-1:0]     dt_q;
	logic [qpr_pkg::NUM_W-1:0]      num_s1;
	logic [qpr_pkg::DEN_W-1:0]      den_s1;

	logic                           accept;
	logic [qpr_pkg::DATA_W-1:0]     dp;
	logic [qpr_pkg::DATA_W-1:0]     dt;
	logic [qpr_pkg::CPR_W-1:0]      cpr_eff;
	logic [qpr_pkg::QUOT_W-1:0]     quot;
	qpr_pkg::div_stat_t             div_stat;
	logic [qpr_pkg::DATA_W-1:0]     q_ext;
	logic [qpr_pkg::DATA_W-1:0]     speed_new;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign dp      = count_q - tick_count_q;
	assign dt      = time_us - tick_time_q;
	assign cpr_eff = (cpr_q == '0) ? qpr_pkg::CPR_W'(1) : cpr_q;

	assign q_ext = {1'b0, quot};
	always_comb begin
		if (div_stat.ovf)
			speed_new = neg_q ? qpr_pkg::SAT_NEG : qpr_pkg::SAT_POS;
		else
			speed_new = neg_q ? (~q_ext + 1'b1) : q_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= qpr_pkg::CPR_RESET;
			min_q <= qpr_pkg::MIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				qpr_pkg::REG_CPR: cpr_q <= cfg_data[qpr_pkg::CPR_W-1:0];
				qpr_pkg::REG_MIN: min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_a_q     <= 1'b0;
			last_b_q     <= 1'b0;
			count_q      <= '0;
			tick_time_q  <= '0;
			tick_count_q <= '0;
			speed_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							qpr_pkg::OP_EDGE_A: begin
								if (level_a != last_a_q)
									count_q <= (level_b != level_a) ? count_q + 1'b1
										: count_q - 1'b1;
								last_a_q    <= level_a;
								out_valid_q <= 1'b1;
							end
							qpr_pkg::OP_EDGE_B: begin
								if (level_b != last_b_q)
									count_q <= (level_b != level_a) ? count_q - 1'b1
										: count_q + 1'b1;
								last_b_q    <= level_b;
								out_valid_q <= 1'b1;
							end
							qpr_pkg::OP_TICK: begin
								tick_time_q  <= time_us;
								tick_count_q <= count_q;
								if (dt > min_q)
									state_q <= S_MUL;
								else
									out_valid_q <= 1'b1;
							end
							default: out_valid_q <= 1'b1;
						endcase
					end
				end
				S_MUL:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						speed_q     <= speed_new;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operands of the speed division
	always_ff @(posedge clk) begin
		if (accept && op == qpr_pkg::OP_TICK) begin
			neg_q <= dp[qpr_pkg::DATA_W-1];
			mag_q <= dp[qpr_pkg::DATA_W-1] ? (~dp + 1'b1) : dp;
			dt_q  <= dt;
		end
		if (state_q == S_MUL) begin
			num_s1 <= qpr_pkg::NUM_W'(mag_q) * qpr_pkg::NUM_W'(qpr_pkg::SPEED_SCALE);
			den_s1 <= qpr_pkg::DEN_W'(cpr_eff) * qpr_pkg::DEN_W'(dt_q);
		end
	end

	qpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LOAD),
		.num    (num_s1),
		.den    (den_s1),
		.quot   (quot),
		.stat   (div_stat)
	);

	assign out_valid    = out_valid_q;
	assign position     = count_q;
	assign speed_rpm_q4 = speed_q;

endmodule

// ===== hdl/qpr_checker.sv =====
// Port-level checks for the quadrature position and rpm block, bound to the top level.
module qpr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [qpr_pkg::DATA_W-1:0] position,
	input  logic signed [qpr_pkg::DATA_W-1:0] speed_rpm_q4
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// a word waiting at the output holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(speed_rpm_q4))
		else $error("stalled output word changed");

	// nothing is taken in while a result waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

	// edge events answer in the next cycle and move position by at most one
	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op == qpr_pkg::OP_EDGE_A || op == qpr_pkg::OP_EDGE_B) |=>
		out_valid && (position == $past(position) || position == $past(position) + 32'sd1
		|| position == $past(position) - 32'sd1))
		else $error("edge event result wrong");

	// ticks and unused opcodes never move the position
	a_tick_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op != qpr_pkg::OP_EDGE_A && op != qpr_pkg::OP_EDGE_B |=>
		position == $past(position))
		else $error("position moved on a tick");

endmodule

bind quadrature_position_and_rpm qpr_checker u_qpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.op           (op),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.position     (position),
	.speed_rpm_q4 (speed_rpm_q4)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the quadrature position and rpm block.
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned MAX_WAIT = 12;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic [qpr_pkg::DATA_W-1:0] position;
		logic [qpr_pkg::DATA_W-1:0] speed;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [qpr_pkg::DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic level_a;
	logic level_b;
	logic [qpr_pkg::DATA_W-1:0] time_us;
	logic out_valid;
	logic out_stall;
	logic signed [qpr_pkg::DATA_W-1:0] position;
	logic signed [qpr_pkg::DATA_W-1:0] speed_rpm_q4;

	// predictor state
	logic [qpr_pkg::CPR_W-1:0] mdl_cpr;
	logic [qpr_pkg::DATA_W-1:0] mdl_min;
	logic mdl_last_a;
	logic mdl_last_b;
	logic [qpr_pkg::DATA_W-1:0] mdl_count;
	logic [qpr_pkg::DATA_W-1:0] mdl_tick_time;
	logic [qpr_pkg::DATA_W-1:0] mdl_tick_count;
	logic [qpr_pkg::DATA_W-1:0] mdl_speed;

	reading_t pending_readings[$];
	int unsigned fail_count;
	int unsigned words_sent;
	int unsigned speed_updates;
	int unsigned saturations;
	int unsigned settings_used;
	int unsigned rx_hold;
	bit no_idle;

	always #5 clk = ~clk;

	quadrature_position_and_rpm i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.level_a(level_a),
		.level_b(level_b),
		.time_us(time_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.speed_rpm_q4(speed_rpm_q4)
	);

	function automatic logic [qpr_pkg::DATA_W-1:0] rpm_q4(logic [qpr_pkg::DATA_W-1:0] dp,
			logic [qpr_pkg::DATA_W-1:0] dt);
		logic neg;
		logic [qpr_pkg::DATA_W-1:0] mag32;
		longint unsigned mag, cpr64, den, scale, q;
		neg = dp[qpr_pkg::DATA_W-1];
		mag32 = neg ? -dp : dp;		// -2^31 keeps its magnitude
		mag = 64'(mag32);
		cpr64 = 64'(mdl_cpr);
		if (cpr64 == 0)
			cpr64 = 1;
		den = cpr64 * 64'(dt);
		if (den == 0)
			den = 1;
		scale = 64'(qpr_pkg::SPEED_SCALE);
		q = (mag * scale) / den;
		if (neg) begin
			if (q >= 64'h8000_0000) begin
				saturations++;
				return qpr_pkg::SAT_NEG;
			end
			mag32 = q[qpr_pkg::DATA_W-1:0];
			return -mag32;
		end
		if (q > 64'h7FFF_FFFF) begin
			saturations++;
			return qpr_pkg::SAT_POS;
		end
		return q[qpr_pkg::DATA_W-1:0];
	endfunction

	function automatic reading_t encoder_step(logic [1:0] w_op, logic a, logic b,
			logic [qpr_pkg::DATA_W-1:0] t);
		reading_t r;
		logic [qpr_pkg::DATA_W-1:0] dp, dt;
		case (w_op)
			qpr_pkg::OP_EDGE_A: begin
				if (a != mdl_last_a)
					mdl_count = (b != a) ? mdl_count + 1'b1 : mdl_count - 1'b1;
				mdl_last_a = a;
			end
			qpr_pkg::OP_EDGE_B: begin
				if (b != mdl_last_b)
					mdl_count = (b != a) ? mdl_count - 1'b1 : mdl_count + 1'b1;
				mdl_last_b = b;
			end
			qpr_pkg::OP_TICK: begin
				dp = mdl_count - mdl_tick_count;
				dt = t - mdl_tick_time;
				if (dt > mdl_min) begin
					mdl_speed = rpm_q4(dp, dt);
					speed_updates++;
				end
				mdl_tick_time = t;
				mdl_tick_count = mdl_count;
			end
			default: ;
		endcase
		r.position = mdl_count;
		r.speed = mdl_speed;
		return r;
	endfunction

	task automatic check_reading(logic [qpr_pkg::DATA_W-1:0] got_pos,
			logic [qpr_pkg::DATA_W-1:0] got_speed);
		reading_t want;
		if (pending_readings.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("[%0t] unexpected result word: position %0d speed %0d", $time,
					$signed(got_pos), $signed(got_speed));
			return;
		end
		want = pending_readings.pop_front();
		if (got_pos !== want.position || got_speed !== want.speed) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("[%0t] mismatch: position exp %0d got %0d, speed exp %0d got %0d",
					$time, $signed(want.position), $signed(got_pos),
					$signed(want.speed), $signed(got_speed));
		end
	endtask

	// result side: check each word taken, then hold off for a random spell
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_reading(position, speed_rpm_q4);
				rx_hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (rx_hold != 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(logic [1:0] w_op, logic a, logic b,
			logic [qpr_pkg::DATA_W-1:0] t);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w_op;
		level_a <= a;
		level_b <= b;
		time_us <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_readings.push_back(encoder_step(w_op, a, b, t));
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
	endtask

	task automatic write_reg(logic idx, logic [qpr_pkg::DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == qpr_pkg::REG_CPR)
			mdl_cpr = value[qpr_pkg::CPR_W-1:0];
		else
			mdl_min = value;
	endtask

	// registers change only once the block has handed back every word
	task automatic configure(logic [qpr_pkg::DATA_W-1:0] cpr_word,
			logic [qpr_pkg::DATA_W-1:0] min_word);
		drain_results();
		write_reg(qpr_pkg::REG_CPR, cpr_word);
		write_reg(qpr_pkg::REG_MIN, min_word);
		settings_used++;
	endtask

	task automatic test_reset_state();
		send_word(OP_UNUSED, 1'b1, 1'b1, '1);
		// interval equal to the minimum: speed held
		send_word(qpr_pkg::OP_TICK, 1'b0, 1'b0, 32'd1000);
	endtask

	task automatic test_edge_counting();
		// one full forward cycle
		send_word(qpr_pkg::OP_EDGE_A, 1'b1, 1'b0, 32'd0);
		send_word(qpr_pkg::OP_EDGE_B, 1'b1, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_EDGE_A, 1'b0, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_EDGE_B, 1'b0, 1'b0, 32'd0);
		// same level again: no step
		send_word(qpr_pkg::OP_EDGE_A, 1'b0, 1'b0, 32'd0);
		// two steps back
		send_word(qpr_pkg::OP_EDGE_B, 1'b0, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_EDGE_A, 1'b1, 1'b1, 32'd0);
		send_word(OP_UNUSED, 1'b0, 1'b0, '1);
	endtask

	task automatic test_speed_update();
		send_word(qpr_pkg::OP_TICK, 1'b0, 1'b0, 32'd2001);
		configure(32'd1, 32'd0);
		send_word(qpr_pkg::OP_EDGE_A, 1'b0, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_EDGE_B, 1'b0, 1'b0, 32'd0);
		send_word(qpr_pkg::OP_EDGE_A, 1'b1, 1'b0, 32'd0);
		send_word(qpr_pkg::OP_TICK, 1'b0, 1'b0, 32'd2002);	// saturates high
		send_word(qpr_pkg::OP_EDGE_A, 1'b0, 1'b0, 32'd0);
		send_word(qpr_pkg::OP_EDGE_B, 1'b0, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_EDGE_A, 1'b1, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_TICK, 1'b1, 1'b1, 32'd2003);	// saturates low
		send_word(qpr_pkg::OP_TICK, 1'b1, 1'b1, 32'hFFFF_FFF0);
		send_word(qpr_pkg::OP_EDGE_A, 1'b0, 1'b1, 32'd0);
		send_word(qpr_pkg::OP_TICK, 1'b0, 1'b1, 32'h0000_0010);	// timestamp wraps
		// low half zero: counts per rev taken as one
		configure(32'hABCD_0000, 32'd0);
		send_word(qpr_pkg::OP_EDGE_B, 1'b0, 1'b0, 32'd0);
		send_word(qpr_pkg::OP_TICK, 1'b0, 1'b0, 32'h000F_4250);
		configure(32'h0000_FFFF, 32'hFFFF_FFFF);
		send_word(qpr_pkg::OP_TICK, 1'b1, 1'b0, 32'h8000_0000);
	endtask

	task automatic run_random_phase(logic [qpr_pkg::DATA_W-1:0] cpr_word,
			logic [qpr_pkg::DATA_W-1:0] min_word, int unsigned n_words);
		logic pin_a, pin_b, dir;
		logic [1:0] w_op;
		logic [qpr_pkg::DATA_W-1:0] now_us;
		int unsigned pick;
		configure(cpr_word, min_word);
		pin_a = mdl_last_a;
		pin_b = mdl_last_b;
		dir = 1'($urandom_range(0, 1));
		repeat (n_words) begin
			if ($urandom_range(0, 39) == 0)
				no_idle = !no_idle;
			if ($urandom_range(0, 19) == 0)
				dir = !dir;
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				// next gray-code step of a real encoder in the current direction
				if ((pin_a == pin_b) == dir) begin
					pin_a = !pin_a;
					w_op = qpr_pkg::OP_EDGE_A;
				end else begin
					pin_b = !pin_b;
					w_op = qpr_pkg::OP_EDGE_B;
				end
				send_word(w_op, pin_a, pin_b, $urandom);
			end else if (pick < 88) begin
				case ($urandom_range(0, 3))
					0: now_us = mdl_tick_time + $urandom_range(0, 2000);
					1: now_us = mdl_tick_time + mdl_min + $urandom_range(0, 1);
					2: now_us = $urandom;
					default: now_us = mdl_tick_time + $urandom_range(1, 60);
				endcase
				send_word(qpr_pkg::OP_TICK, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), now_us);
			end else begin
				send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom);
				pin_a = mdl_last_a;
				pin_b = mdl_last_b;
			end
		end
	endtask

	task automatic test_random_quadrature();
		run_random_phase(32'd512, 32'd1000, 270);
		run_random_phase(32'd1, 32'd0, 270);
		run_random_phase($urandom_range(1, 65535), $urandom_range(0, 5000), 270);
		run_random_phase($urandom & 32'hFFFF_0000, $urandom_range(0, 200), 270);
		run_random_phase(32'h0000_FFFF, 32'hFFFF_FFFF, 270);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = qpr_pkg::REG_CPR;
		cfg_data = '0;
		in_valid = 1'b0;
		op = qpr_pkg::OP_EDGE_A;
		level_a = 1'b0;
		level_b = 1'b0;
		time_us = '0;
		out_stall = 1'b0;
		no_idle = 1'b0;
		rx_hold = 0;
		fail_count = 0;
		words_sent = 0;
		speed_updates = 0;
		saturations = 0;
		settings_used = 1;
		mdl_cpr = qpr_pkg::CPR_RESET;
		mdl_min = qpr_pkg::MIN_RESET;
		mdl_last_a = 1'b0;
		mdl_last_b = 1'b0;
		mdl_count = '0;
		mdl_tick_time = '0;
		mdl_tick_count = '0;
		mdl_speed = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_edge_counting();
		test_speed_update();
		test_random_quadrature();

		in_valid <= 1'b0;
		for (int i = 0; i < 2000 && pending_readings.size() != 0; i++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (pending_readings.size() != 0) begin
			$display("%0d expected words never arrived", pending_readings.size());
			fail_count += pending_readings.size();
		end
		$display("Covered %0d input words over %0d register settings", words_sent,
			settings_used);
		$display("%0d speed updates, %0d of them saturated; %0d failures", speed_updates,
			saturations, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
